// ----- sv/xxtea_pkg.sv -----
package xxtea_pkg;

	localparam int MAX_WORDS = 16;
	localparam int ADDR_W    = (MAX_WORDS > 2) ? $clog2(MAX_WORDS) : 1;
	localparam int CNT_W     = $clog2(MAX_WORDS + 1);
	localparam int ROUNDS_W  = $clog2(6 + 52 / 2 + 1);
	localparam int CFG_IDX_W = 3;

	localparam logic [31:0] DELTA = 32'h9e3779b9;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd4;

	typedef struct packed {
		logic [31:0] data_word;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_word;
		logic        result_last;
		logic        too_long;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_RD,
		S_MX,
		S_WR,
		S_OUT
	} state_t;

	// XXTEA mixing function, key word already selected
	function automatic logic [31:0] mix(input logic [31:0] y, input logic [31:0] z,
		input logic [31:0] sum, input logic [31:0] k);
		logic [31:0] a;
		logic [31:0] b;
		a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
		b = (sum ^ y) + (k ^ z);
		return a ^ b;
	endfunction

	// 6 + 52/n, as a constant lookup over the word count
	function automatic logic [ROUNDS_W-1:0] rounds_for(input logic [CNT_W-1:0] n);
		int r;
		r = 0;
		for (int q = 1; q <= 52; q++) begin
			if (q * int'(n) <= 52)
				r = q;
		end
		return ROUNDS_W'(6 + r);
	endfunction

endpackage

// ----- sv/xxtea_block_cipher.sv -----
// Loading accepts one item per cycle; busy stays low until the item marked last.
// A block of n >= 2 words then goes through the cipher work (one word update at a
// time through the single block RAM port pair, in the states RD, MX and WR) and n
// reads; results follow their reads in the next cycle, one per cycle. A single
// word skips the cipher work.
// The receiver cannot stall. Reset clears control, key and mode; RAM stays undefined.
module xxtea_block_cipher
	import xxtea_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_item_t             block_item,
	output logic                 result_valid,
	output out_item_t            result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	state_t state_q, state_d;

	logic [3:0][31:0]    key_q;
	logic                decrypt_q;
	logic [CNT_W-1:0]    count_q;
	logic                ovf_q;
	logic                blk_ovf_q;
	logic [CNT_W-1:0]    n_q;
	logic [31:0]         first_q;
	logic [31:0]         lastw_q;
	logic [ADDR_W-1:0]   p_q;
	logic [ROUNDS_W-1:0] rounds_q;
	logic [31:0]         sum_q;
	logic [31:0]         other_q;
	logic [31:0]         cur_q;
	logic [31:0]         nb_q;
	logic [31:0]         mix_q;
	logic [ADDR_W-1:0]   k_q;
	logic                valid_s1;
	logic                last_s1;

	logic                accept;
	logic                room;
	logic [CNT_W-1:0]    n_new;
	logic [ADDR_W-1:0]   nm1;
	logic                round_end;
	logic [ROUNDS_W-1:0] rounds_init;
	logic [31:0]         new_word;
	logic [31:0]         key_sel;

	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [31:0]         wdata;
	logic [ADDR_W-1:0]   raddr;
	logic [31:0]         rdata;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign room      = (count_q < CNT_W'(MAX_WORDS));
	assign n_new     = room ? count_q + 1'b1 : count_q;
	assign nm1       = ADDR_W'(n_q - 1'b1);
	assign round_end = decrypt_q ? (p_q == '0) : (p_q == nm1);
	assign rounds_init = rounds_for(n_q);
	assign key_sel   = key_q[2'(p_q) ^ sum_q[3:2]];
	assign new_word  = decrypt_q ? cur_q - mix_q : cur_q + mix_q;

	xxtea_ram #(
		.WIDTH(32),
		.DEPTH(MAX_WORDS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = p_q;
		wdata   = new_word;
		raddr   = k_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					we    = room;
					waddr = ADDR_W'(count_q);
					wdata = block_item.data_word;
					if (block_item.last_word)
						state_d = (n_new >= CNT_W'(2)) ? S_SETUP : S_OUT;
				end
			end
			S_SETUP: state_d = S_RD;
			S_RD: begin
				// neighbor word: y for encryption, z for decryption
				if (decrypt_q)
					raddr = (p_q == '0) ? nm1 : p_q - 1'b1;
				else
					raddr = (p_q == nm1) ? '0 : p_q + 1'b1;
				state_d = S_MX;
			end
			S_MX: state_d = S_WR;
			S_WR: begin
				we = 1'b1;
				if (round_end && rounds_q == ROUNDS_W'(1))
					state_d = S_OUT;
				else
					state_d = S_RD;
			end
			S_OUT: begin
				raddr = k_q;
				if (k_q == nm1)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			decrypt_q <= 1'b0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			blk_ovf_q <= 1'b0;
			n_q       <= '0;
			p_q       <= '0;
			rounds_q  <= '0;
			sum_q     <= '0;
			k_q       <= '0;
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_KEY_0: key_q[0] <= cfg_data;
					CFG_KEY_1: key_q[1] <= cfg_data;
					CFG_KEY_2: key_q[2] <= cfg_data;
					CFG_KEY_3: key_q[3] <= cfg_data;
					CFG_MODE:  decrypt_q <= cfg_data[0];
					default: ;
				endcase
			end

			valid_s1 <= (state_q == S_OUT);
			last_s1  <= (state_q == S_OUT) && (k_q == nm1);

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (block_item.last_word) begin
							count_q   <= '0;
							ovf_q     <= 1'b0;
							blk_ovf_q <= ovf_q || !room;
							n_q       <= n_new;
							k_q       <= '0;
						end else begin
							count_q <= n_new;
							ovf_q   <= ovf_q || !room;
						end
					end
				end
				S_SETUP: begin
					rounds_q <= rounds_init;
					sum_q    <= decrypt_q ? 32'(32'(rounds_init) * DELTA) : DELTA;
					p_q      <= decrypt_q ? nm1 : '0;
				end
				S_WR: begin
					if (round_end) begin
						rounds_q <= rounds_q - 1'b1;
						sum_q    <= decrypt_q ? sum_q - DELTA : sum_q + DELTA;
						p_q      <= decrypt_q ? nm1 : '0;
					end else begin
						p_q <= decrypt_q ? p_q - 1'b1 : p_q + 1'b1;
					end
					k_q <= '0;
				end
				S_OUT: k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (accept && room) begin
			if (count_q == '0)
				first_q <= block_item.data_word;
			lastw_q <= block_item.data_word;
		end
		unique case (state_q)
			S_SETUP: begin
				// encrypt keeps z in other_q, decrypt keeps y
				other_q <= decrypt_q ? first_q : lastw_q;
				cur_q   <= decrypt_q ? lastw_q : first_q;
			end
			S_MX: begin
				nb_q  <= rdata;
				mix_q <= decrypt_q ? mix(other_q, rdata, sum_q, key_sel)
				                   : mix(rdata, other_q, sum_q, key_sel);
			end
			S_WR: begin
				other_q <= new_word;
				cur_q   <= nb_q;
			end
			default: ;
		endcase
	end

	assign result_valid = valid_s1;
	assign result       = '{result_word: rdata, result_last: last_s1, too_long: blk_ovf_q};

endmodule

// ----- sv/xxtea_ram.sv -----
module xxtea_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule
